FILE: rtl/core/dwr_pkg.sv
// shared constants, types and codes for the draw-without-repeat selector
`timescale 1ns / 1ps
`default_nettype none

package dwr_pkg;

    // index range size default
    localparam int RANGE_SIZE_DEF = 256;

    // picked map row geometry
    localparam int ROW_W     = 32;
    localparam int OFF_W     = $clog2(ROW_W);
    localparam int ROW_CNT_W = $clog2(ROW_W + 1);

    // field widths
    localparam int IDX_W = 8;
    localparam int UB_W  = 9;
    localparam int LS_W  = 8;
    localparam int ST_W  = 2;
    localparam int FC_W  = 9;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_START = 1'b1;

    localparam logic [UB_W-1:0] UB_RESET = 9'd256;
    localparam logic [LS_W-1:0] LS_RESET = 8'd0;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_OUT_RANGE = 2'd2;

    typedef logic [ROW_W-1:0] t_row;

    // result of one pass of the row scan unit
    typedef struct packed {
        logic                 found;
        logic [OFF_W-1:0]     off;
        logic [ROW_CNT_W-1:0] cnt;
    } t_row_res;

endpackage

`default_nettype wire

FILE: rtl/core/draw_without_repeat_selector_core.sv
// draw-without-repeat selector: sequencer around the picked map and the row scan unit
// a free proposal runs S_PROP, S_PICK and S_FIN, which registers the result strobe; a draw
//   on the pointer adds S_SK_RD and S_SK_CHK per row the pointer skip visits, plus S_SK_RD
//   if it runs off the range end; a taken proposal adds S_LP_RD, S_LP_WR to read and mark it
// the first draw after reset or a register write re-skips the pointer, S_SK_RD and S_SK_CHK
//   per row visited, then recounts from the pointer to the bound, S_CNT_RD and S_CNT_ACC per
//   row, or S_CNT_RD alone if empty; start is taken only in S_IDLE, so draws never overlap
// reset: synchronous active low; the map clears at once through row valid bits, no sweep
`timescale 1ns / 1ps
`default_nettype none

module draw_without_repeat_selector_core #(
    parameter int RANGE_SIZE = dwr_pkg::RANGE_SIZE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // draw command
    input  wire                              start,
    output logic                             busy,
    input  wire  [dwr_pkg::IDX_W-1:0]        i_proposed_index,
    // result word
    output logic                             o_result_valid,
    output logic [dwr_pkg::IDX_W-1:0]        o_chosen_index,
    output logic [dwr_pkg::ST_W-1:0]         o_status,
    output logic [dwr_pkg::FC_W-1:0]         o_free_count,
    output logic                             o_now_empty,
    // register writes
    input  wire                              i_cfg_we,
    input  wire  [dwr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [dwr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    // map geometry: rows of ROW_W bits, pointer wide enough to hold RANGE_SIZE
    localparam int ROWS  = (RANGE_SIZE + dwr_pkg::ROW_W - 1) / dwr_pkg::ROW_W;
    localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PTR_W = RIW + dwr_pkg::OFF_W + 1;
    localparam int CW    = (PTR_W > dwr_pkg::UB_W) ? PTR_W : dwr_pkg::UB_W;

    localparam logic [PTR_W-1:0] RANGE_P = PTR_W'(RANGE_SIZE);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_SK_RD   = 10'b00_0000_0010,   // read row at pointer
        S_SK_CHK  = 10'b00_0000_0100,   // look for a free bit at or above pointer
        S_CNT_RD  = 10'b00_0000_1000,   // read next row for the recount
        S_CNT_ACC = 10'b00_0001_0000,   // add free bits of that row
        S_PROP    = 10'b00_0010_0000,   // range checks, read proposal row
        S_PICK    = 10'b00_0100_0000,   // proposal free or taken
        S_LP_RD   = 10'b00_1000_0000,   // read pointer row
        S_LP_WR   = 10'b01_0000_0000,   // mark pointer index picked
        S_FIN     = 10'b10_0000_0000    // register the result word
    } t_state;

    t_state                      r_state, n_state;
    logic [dwr_pkg::UB_W-1:0]    r_ub, n_ub;
    logic [PTR_W-1:0]            r_lp, n_lp;
    logic [PTR_W-1:0]            r_free, n_free;
    logic                        r_dirty, n_dirty;
    logic                        r_pre, n_pre;
    logic [dwr_pkg::IDX_W-1:0]   r_prop, n_prop;
    logic [RIW-1:0]              r_row, n_row;
    logic [PTR_W-1:0]            r_chosen, n_chosen;
    logic [dwr_pkg::ST_W-1:0]    r_st, n_st;

    logic                        r_o_vld, n_o_vld;
    logic [dwr_pkg::IDX_W-1:0]   r_o_chosen, n_o_chosen;
    logic [dwr_pkg::ST_W-1:0]    r_o_st, n_o_st;
    logic [dwr_pkg::FC_W-1:0]    r_o_free, n_o_free;
    logic                        r_o_empty, n_o_empty;

    // map port and scan unit hookup
    logic                        w_we;
    logic [RIW-1:0]              w_waddr;
    dwr_pkg::t_row               w_wdata;
    logic [RIW-1:0]              w_raddr;
    dwr_pkg::t_row               w_rdata;
    logic [PTR_W-1:0]            w_base;
    logic [PTR_W-1:0]            w_hi;
    dwr_pkg::t_row_res           w_res;

    // derived values
    logic [PTR_W-1:0]            w_eub;
    logic [PTR_W-1:0]            w_prop_p;
    logic [PTR_W-1:0]            w_next_base;
    logic [PTR_W-1:0]            w_ls_load;
    logic                        w_prop_taken;

    // upper bound above the range acts as the range size
    assign w_eub = (CW'(r_ub) > CW'(RANGE_SIZE)) ? RANGE_P : PTR_W'(r_ub);

    // proposal in pointer width, only used once it is known to be below the bound
    assign w_prop_p     = PTR_W'(r_prop);
    assign w_base       = {1'b0, r_row, {dwr_pkg::OFF_W{1'b0}}};
    assign w_next_base  = w_base + PTR_W'(dwr_pkg::ROW_W);
    assign w_prop_taken = w_rdata[w_prop_p[dwr_pkg::OFF_W-1:0]];
    assign w_ls_load    = (CW'(i_cfg_wdata[dwr_pkg::LS_W-1:0]) > CW'(RANGE_SIZE)) ?
                          RANGE_P : PTR_W'(i_cfg_wdata[dwr_pkg::LS_W-1:0]);

    // recount looks up to the bound, the pointer skip up to the range end
    assign w_hi = (r_state == S_CNT_ACC) ? w_eub : RANGE_P;

    dwr_map_ram #(
        .ROW_IDX_W (RIW)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dwr_row_unit #(
        .PTR_W (PTR_W)
    ) u_scan (
        .i_row  (w_rdata),
        .i_base (w_base),
        .i_lo   (r_lp),
        .i_hi   (w_hi),
        .o_res  (w_res)
    );

    always_comb begin
        n_state    = r_state;
        n_ub       = r_ub;
        n_lp       = r_lp;
        n_free     = r_free;
        n_dirty    = r_dirty;
        n_pre      = r_pre;
        n_prop     = r_prop;
        n_row      = r_row;
        n_chosen   = r_chosen;
        n_st       = r_st;
        n_o_vld    = 1'b0;
        n_o_chosen = r_o_chosen;
        n_o_st     = r_o_st;
        n_o_free   = r_o_free;
        n_o_empty  = r_o_empty;
        w_raddr    = r_row;
        w_we       = 1'b0;
        w_waddr    = r_row;
        w_wdata    = w_rdata;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_prop = i_proposed_index;
                    // after a register write the pointer and count need a refresh
                    n_pre   = r_dirty;
                    n_state = r_dirty ? S_SK_RD : S_PROP;
                    if (r_dirty) begin
                        n_free = '0;
                    end
                end
            end

            S_SK_RD: begin
                if (r_lp >= RANGE_P) begin
                    n_state = r_pre ? S_CNT_RD : S_FIN;
                end else begin
                    w_raddr = r_lp[dwr_pkg::OFF_W +: RIW];
                    n_row   = r_lp[dwr_pkg::OFF_W +: RIW];
                    n_state = S_SK_CHK;
                end
            end

            S_SK_CHK: begin
                if (w_res.found) begin
                    n_lp    = w_base + PTR_W'(w_res.off);
                    n_state = r_pre ? S_CNT_RD : S_FIN;
                end else begin
                    // whole rest of the row is picked, move to the next row
                    n_lp    = (w_next_base >= RANGE_P) ? RANGE_P : w_next_base;
                    n_state = S_SK_RD;
                end
            end

            S_CNT_RD: begin
                if (r_lp >= w_eub) begin
                    n_dirty = 1'b0;
                    n_state = S_PROP;
                end else begin
                    n_state = S_CNT_ACC;
                end
            end

            S_CNT_ACC: begin
                n_free = r_free + PTR_W'(w_res.cnt);
                if (w_next_base >= w_eub) begin
                    n_dirty = 1'b0;
                    n_state = S_PROP;
                end else begin
                    n_row   = r_row + RIW'(1);
                    w_raddr = r_row + RIW'(1);
                    n_state = S_CNT_RD;
                end
            end

            S_PROP: begin
                n_chosen = '0;
                if (r_lp >= w_eub) begin
                    n_st    = dwr_pkg::ST_EMPTY;
                    n_state = S_FIN;
                end else if (CW'(r_prop) >= CW'(w_eub)) begin
                    n_st    = dwr_pkg::ST_OUT_RANGE;
                    n_state = S_FIN;
                end else begin
                    n_st    = dwr_pkg::ST_OK;
                    w_raddr = w_prop_p[dwr_pkg::OFF_W +: RIW];
                    n_row   = w_prop_p[dwr_pkg::OFF_W +: RIW];
                    n_state = S_PICK;
                end
            end

            S_PICK: begin
                if (!w_prop_taken) begin
                    // free proposal: mark it, count drops only if at or above pointer
                    w_we     = 1'b1;
                    w_wdata  = w_rdata | (dwr_pkg::t_row'(1) << w_prop_p[dwr_pkg::OFF_W-1:0]);
                    n_chosen = w_prop_p;
                    if (w_prop_p >= r_lp) begin
                        n_free = r_free - PTR_W'(1);
                    end
                    if (w_prop_p == r_lp) begin
                        // drawn at the pointer itself: move the pointer on
                        n_pre   = 1'b0;
                        n_state = S_SK_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    // taken: the pointer index is the draw
                    n_chosen = r_lp;
                    n_free   = r_free - PTR_W'(1);
                    n_state  = S_LP_RD;
                end
            end

            S_LP_RD: begin
                w_raddr = r_lp[dwr_pkg::OFF_W +: RIW];
                n_row   = r_lp[dwr_pkg::OFF_W +: RIW];
                n_state = S_LP_WR;
            end

            S_LP_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata | (dwr_pkg::t_row'(1) << r_lp[dwr_pkg::OFF_W-1:0]);
                n_pre   = 1'b0;
                n_state = S_SK_RD;
            end

            S_FIN: begin
                n_o_vld    = 1'b1;
                n_o_chosen = dwr_pkg::IDX_W'(r_chosen);
                n_o_st     = r_st;
                n_o_free   = dwr_pkg::FC_W'(r_free);
                n_o_empty  = (r_lp >= w_eub);
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register writes are to arrive only while idle; the block itself does not enforce it
        if (i_cfg_we) begin
            case (i_cfg_idx)
                dwr_pkg::REG_UPPER_BOUND: begin
                    n_ub    = i_cfg_wdata[dwr_pkg::UB_W-1:0];
                    n_dirty = 1'b1;
                end
                dwr_pkg::REG_LOWER_START: begin
                    n_lp    = w_ls_load;
                    n_dirty = 1'b1;
                end
                default: begin
                    n_dirty = r_dirty;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ub    <= dwr_pkg::UB_RESET;
            r_lp    <= (CW'(dwr_pkg::LS_RESET) > CW'(RANGE_SIZE)) ?
                       RANGE_P : PTR_W'(dwr_pkg::LS_RESET);
            r_dirty <= 1'b1;
            r_pre   <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ub    <= n_ub;
            r_lp    <= n_lp;
            r_dirty <= n_dirty;
            r_pre   <= n_pre;
            r_o_vld <= n_o_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_free     <= n_free;
        r_prop     <= n_prop;
        r_row      <= n_row;
        r_chosen   <= n_chosen;
        r_st       <= n_st;
        r_o_chosen <= n_o_chosen;
        r_o_st     <= n_o_st;
        r_o_free   <= n_o_free;
        r_o_empty  <= n_o_empty;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_o_vld;
    assign o_chosen_index = r_o_chosen;
    assign o_status       = r_o_st;
    assign o_free_count   = r_o_free;
    assign o_now_empty    = r_o_empty;

endmodule

`default_nettype wire

FILE: rtl/core/dwr_map_ram.sv
// picked map storage: one row per address, row valid bits stand in for a clear
`timescale 1ns / 1ps
`default_nettype none

module dwr_map_ram #(
    parameter int ROW_IDX_W = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_we,
    input  wire  [ROW_IDX_W-1:0]  i_waddr,
    input  wire  dwr_pkg::t_row   i_wdata,
    input  wire  [ROW_IDX_W-1:0]  i_raddr,
    output dwr_pkg::t_row         o_rdata
);

    localparam int DEPTH = 1 << ROW_IDX_W;

    dwr_pkg::t_row  r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_vld;
    dwr_pkg::t_row  r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_we) begin
            r_row_vld[i_waddr] <= 1'b1;
        end
    end

    // a row never written reads as nothing picked
    always_ff @(posedge i_clk) begin
        r_rdata <= r_row_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/dwr_row_unit.sv
// shared row scan unit: first free bit and free count within a window
`timescale 1ns / 1ps
`default_nettype none

module dwr_row_unit #(
    parameter int PTR_W = 9
) (
    input  wire  dwr_pkg::t_row     i_row,
    input  wire  [PTR_W-1:0]        i_base,
    input  wire  [PTR_W-1:0]        i_lo,
    input  wire  [PTR_W-1:0]        i_hi,
    output dwr_pkg::t_row_res       o_res
);

    dwr_pkg::t_row             w_free;
    logic [PTR_W-1:0]          w_idx;
    logic [dwr_pkg::OFF_W-1:0] w_off;

    always_comb begin
        w_idx = '0;
        for (int b = 0; b < dwr_pkg::ROW_W; b++) begin
            w_idx     = i_base + PTR_W'(b);
            w_free[b] = !i_row[b] && (w_idx >= i_lo) && (w_idx < i_hi);
        end
    end

    // lowest free bit wins
    always_comb begin
        w_off = '0;
        for (int b = dwr_pkg::ROW_W - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_off = dwr_pkg::OFF_W'(b);
            end
        end
    end

    assign o_res.found = |w_free;
    assign o_res.off   = w_off;
    assign o_res.cnt   = dwr_pkg::ROW_CNT_W'($countones(w_free));

endmodule

`default_nettype wire
